// ----- rtl/eabv_pkg.sv -----
// Package for the Euler angle to basis vector block.
// Holds the fixed-point formats, the series constants and the rounding helpers.
// Used by eabv_sincos and euler_angles_to_basis_vectors_top.
package eabv_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VW = FRAC_BITS + 2;
  localparam int LANE_STAGES = 28;
  localparam int PIPE_STAGES = LANE_STAGES + 3;

  localparam logic [15:0] OUT_ONE = 16'(1 << FRAC_BITS);
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [16:0] TURN_UNITS = 17'd23040;
  localparam logic [16:0] TWO_TURNS = 17'd46080;
  localparam logic [14:0] QUARTER_UNITS = 15'd5760;
  localparam logic [14:0] HALF_UNITS = 15'd11520;
  localparam logic [14:0] THREE_QUARTERS = 15'd17280;
  localparam logic [31:0] RECIP_45 = 32'd3054198966;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  function automatic logic [7:0] cos_div(input int j);
    case (j)
      0: cos_div = 8'd182;
      1: cos_div = 8'd132;
      2: cos_div = 8'd90;
      3: cos_div = 8'd56;
      4: cos_div = 8'd30;
      5: cos_div = 8'd12;
      default: cos_div = 8'd2;
    endcase
  endfunction

  // Reciprocals are floor(2^33 / d).
  function automatic logic [32:0] cos_recip(input int j);
    case (j)
      0: cos_recip = 33'd47197442;
      1: cos_recip = 33'd65075262;
      2: cos_recip = 33'd95443717;
      3: cos_recip = 33'd153391689;
      4: cos_recip = 33'd286331153;
      5: cos_recip = 33'd715827882;
      default: cos_recip = 33'd4294967296;
    endcase
  endfunction

  function automatic logic [7:0] sin_div(input int j);
    case (j)
      0: sin_div = 8'd156;
      1: sin_div = 8'd110;
      2: sin_div = 8'd72;
      3: sin_div = 8'd42;
      4: sin_div = 8'd20;
      default: sin_div = 8'd6;
    endcase
  endfunction

  function automatic logic [32:0] sin_recip(input int j);
    case (j)
      0: sin_recip = 33'd55063683;
      1: sin_recip = 33'd78090314;
      2: sin_recip = 33'd119304647;
      3: sin_recip = 33'd204522252;
      4: sin_recip = 33'd429496729;
      default: sin_recip = 33'd1431655765;
    endcase
  endfunction

  // Q30 to FRAC_BITS, round half up, capped at one.
  function automatic logic signed [VW-1:0] q30_round(input logic [30:0] v);
    logic [31:0] r;
    r = (32'(v) + 32'(1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (r > 32'(1 << FRAC_BITS)) begin
      r = 32'(1 << FRAC_BITS);
    end
    q30_round = VW'(r);
  endfunction

  function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = (2*VW)'(a) * (2*VW)'(b) + (2*VW)'(1 << (FRAC_BITS - 1));
    fmul = VW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [15:0] sat_pack(input logic signed [VW:0] v);
    logic signed [VW:0] lim;
    logic signed [VW:0] r;
    lim = (VW+1)'(1 << FRAC_BITS);
    r = v;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    sat_pack = 16'(r);
  endfunction

endpackage

// ----- rtl/eabv_sincos.sv -----
// Pipelined sine and cosine of one angle in 1/64 degree.
// Reduces the angle, converts it to Q30 radians and runs both series.
// Depends on eabv_pkg; stage loads come from the top level's flow control.
module eabv_sincos (
  input  logic                              clk,
  input  logic [eabv_pkg::LANE_STAGES-1:0]  en,
  input  logic signed [15:0]                angle,
  output logic signed [eabv_pkg::VW-1:0]    sin_out,
  output logic signed [eabv_pkg::VW-1:0]    cos_out
);
  import eabv_pkg::*;

  logic [16:0] u0, u1, u2, u3;
  logic [14:0] a_red;
  logic [1:0]  q_d [1:26];
  logic [12:0] r1;
  logic [44:0] v2;
  logic [36:0] w3;
  logic [31:0] qe3;
  logic [30:0] x_d [4:23];
  logic [31:0] x2_d [5:23];

  logic [31:0] pc_a [7];
  logic [31:0] pc_b [7];
  logic [31:0] qc_b [7];
  logic [30:0] tc [7];
  logic [31:0] ps_a [7];
  logic [31:0] ps_b [7];
  logic [31:0] qs_b [6];
  logic [30:0] ts [7];

  // Wrap into one turn: the offset input lies below four turns.
  always_comb begin
    u0 = 17'(18'(angle) + 18'(TWO_TURNS));
    u1 = (u0 >= TURN_UNITS) ? u0 - TURN_UNITS : u0;
    u2 = (u1 >= TURN_UNITS) ? u1 - TURN_UNITS : u1;
    u3 = (u2 >= TURN_UNITS) ? u2 - TURN_UNITS : u2;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_red <= u3[14:0];
    end
    if (en[1]) begin
      if (a_red >= THREE_QUARTERS) begin
        q_d[1] <= QUAD_3;
        r1 <= 13'(a_red - THREE_QUARTERS);
      end else if (a_red >= HALF_UNITS) begin
        q_d[1] <= QUAD_2;
        r1 <= 13'(a_red - HALF_UNITS);
      end else if (a_red >= QUARTER_UNITS) begin
        q_d[1] <= QUAD_1;
        r1 <= 13'(a_red - QUARTER_UNITS);
      end else begin
        q_d[1] <= QUAD_0;
        r1 <= a_red[12:0];
      end
    end
    if (en[2]) begin
      v2 <= 45'(r1) * 45'(PI_Q30) + 45'(QUARTER_UNITS);
    end
  end

  // Division by 11520 is a shift by 8 and a reciprocal multiply by 1/45.
  logic [68:0] m45;
  logic [37:0] rem45;
  assign m45 = 69'(v2[44:8]) * 69'(RECIP_45);
  assign rem45 = 38'(w3) - 38'(qe3) * 38'd45;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      w3 <= v2[44:8];
      qe3 <= m45[68:37];
    end
    if (en[4]) begin
      x_d[4] <= 31'(qe3 + 32'(rem45 >= 38'd45));
    end
    if (en[5]) begin
      x_d[5] <= x_d[4];
      x2_d[5] <= 32'((62'(x_d[4]) * 62'(x_d[4])) >> 30);
    end
  end

  genvar k, j;
  generate
    for (k = 2; k <= 26; k++) begin : g_quad
      always_ff @(posedge clk) begin
        if (en[k]) begin
          q_d[k] <= q_d[k-1];
        end
      end
    end
    for (k = 6; k <= 23; k++) begin : g_x
      always_ff @(posedge clk) begin
        if (en[k]) begin
          x_d[k] <= x_d[k-1];
          x2_d[k] <= x2_d[k-1];
        end
      end
    end

    for (j = 0; j < 7; j++) begin : g_step
      logic [30:0] tc_in;
      logic [64:0] mc;
      logic [39:0] rem_c;
      logic [31:0] qf_c;
      logic signed [32:0] diff_c;

      assign tc_in = (j == 0) ? ONE_Q30 : tc[(j == 0) ? 0 : j-1];
      assign mc = 65'(pc_a[j]) * 65'(cos_recip(j));
      assign rem_c = 40'(pc_b[j]) - 40'(qc_b[j]) * 40'(cos_div(j));
      assign qf_c = qc_b[j] + 32'(rem_c >= 40'(cos_div(j)));
      assign diff_c = 33'(ONE_Q30) - 33'(qf_c);

      always_ff @(posedge clk) begin
        if (en[6+3*j]) begin
          pc_a[j] <= 32'((63'(x2_d[5+3*j]) * 63'(tc_in)) >> 30);
        end
        if (en[7+3*j]) begin
          pc_b[j] <= pc_a[j];
          qc_b[j] <= mc[64:33];
        end
        if (en[8+3*j]) begin
          tc[j] <= diff_c[32] ? 31'd0 : diff_c[30:0];
        end
      end

      if (j < 6) begin : g_sin
        logic [30:0] ts_in;
        logic [64:0] ms;
        logic [39:0] rem_s;
        logic [31:0] qf_s;
        logic signed [32:0] diff_s;

        assign ts_in = (j == 0) ? ONE_Q30 : ts[(j == 0) ? 0 : j-1];
        assign ms = 65'(ps_a[j]) * 65'(sin_recip(j));
        assign rem_s = 40'(ps_b[j]) - 40'(qs_b[j]) * 40'(sin_div(j));
        assign qf_s = qs_b[j] + 32'(rem_s >= 40'(sin_div(j)));
        assign diff_s = 33'(ONE_Q30) - 33'(qf_s);

        always_ff @(posedge clk) begin
          if (en[6+3*j]) begin
            ps_a[j] <= 32'((63'(x2_d[5+3*j]) * 63'(ts_in)) >> 30);
          end
          if (en[7+3*j]) begin
            ps_b[j] <= ps_a[j];
            qs_b[j] <= ms[64:33];
          end
          if (en[8+3*j]) begin
            ts[j] <= diff_s[32] ? 31'd0 : diff_s[30:0];
          end
        end
      end else begin : g_sin_final
        // The sine series ends with one multiply by x; it then rides along.
        always_ff @(posedge clk) begin
          if (en[6+3*j]) begin
            ps_a[j] <= 32'((62'(x_d[23]) * 62'(ts[5])) >> 30);
          end
          if (en[7+3*j]) begin
            ps_b[j] <= ps_a[j];
          end
          if (en[8+3*j]) begin
            ts[j] <= ps_b[j][30:0];
          end
        end
      end
    end
  endgenerate

  logic signed [VW-1:0] sq, cq;
  assign sq = q30_round(ts[6]);
  assign cq = q30_round(tc[6]);

  always_ff @(posedge clk) begin
    if (en[27]) begin
      unique case (q_d[26])
        QUAD_0: begin
          sin_out <= sq;
          cos_out <= cq;
        end
        QUAD_1: begin
          sin_out <= cq;
          cos_out <= -sq;
        end
        QUAD_2: begin
          sin_out <= -sq;
          cos_out <= -cq;
        end
        default: begin
          sin_out <= -cq;
          cos_out <= sq;
        end
      endcase
    end
  end

endmodule

// ----- rtl/euler_angles_to_basis_vectors_top.sv -----
// Converts pitch, yaw and roll (1/64 degree, signed) into the forward, right
// and up unit vectors in Q2.14. One item is accepted per cycle while the output
// is not stalled. The pipeline holds 28 stages of the sine and cosine lanes
// (angle reduction, series and quadrant fix-up), the series taking seven Horner
// steps of three stages each (multiply, reciprocal multiply, correction), then
// two product stages and a sum and saturate stage. Every stage holds its item
// under a stall, so bubbles close up. Depends on eabv_pkg and eabv_sincos.
module euler_angles_to_basis_vectors_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [47:0]   s_tdata,   // pitch_angle, yaw_angle, roll_angle
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata    // forward_x, forward_y, forward_z, right_x,
                                   // right_y, right_z, up_x, up_y, up_z
);
  import eabv_pkg::*;

  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES:0]   ready;

  assign ready[PIPE_STAGES] = m_tready;
  genvar k;
  generate
    for (k = 0; k < PIPE_STAGES; k++) begin : g_flow
      assign ready[k] = !valid[k] || ready[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        if (ready[i]) begin
          valid[i] <= (i == 0) ? s_tvalid : valid[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign s_tready = ready[0];
  assign m_tvalid = valid[PIPE_STAGES-1];

  logic signed [VW-1:0] sp, cp, sy, cy, sr, cr;

  eabv_sincos u_pitch (
    .clk(clk), .en(ready[LANE_STAGES-1:0]), .angle(s_tdata[15:0]),
    .sin_out(sp), .cos_out(cp)
  );
  eabv_sincos u_yaw (
    .clk(clk), .en(ready[LANE_STAGES-1:0]), .angle(s_tdata[31:16]),
    .sin_out(sy), .cos_out(cy)
  );
  eabv_sincos u_roll (
    .clk(clk), .en(ready[LANE_STAGES-1:0]), .angle(s_tdata[47:32]),
    .sin_out(sr), .cos_out(cr)
  );

  localparam int S1 = LANE_STAGES;

  logic signed [VW-1:0] srsp, crsp, sp1, cp1, sy1, cy1, sr1, cr1;
  logic signed [VW-1:0] p_cpcy, p_cpsy, p_nsp, p_srspcy, p_crsy, p_srspsy, p_crcy;
  logic signed [VW-1:0] p_srcp, p_crspcy, p_srsy, p_crspsy, p_srcy, p_crcp;

  always_ff @(posedge clk) begin
    if (ready[S1]) begin
      srsp <= fmul(sr, sp);
      crsp <= fmul(cr, sp);
      sp1 <= sp;
      cp1 <= cp;
      sy1 <= sy;
      cy1 <= cy;
      sr1 <= sr;
      cr1 <= cr;
    end
    if (ready[S1+1]) begin
      p_cpcy <= fmul(cp1, cy1);
      p_cpsy <= fmul(cp1, sy1);
      p_nsp <= sp1;
      p_srspcy <= fmul(srsp, cy1);
      p_crsy <= fmul(cr1, sy1);
      p_srspsy <= fmul(srsp, sy1);
      p_crcy <= fmul(cr1, cy1);
      p_srcp <= fmul(sr1, cp1);
      p_crspcy <= fmul(crsp, cy1);
      p_srsy <= fmul(sr1, sy1);
      p_crspsy <= fmul(crsp, sy1);
      p_srcy <= fmul(sr1, cy1);
      p_crcp <= fmul(cr1, cp1);
    end
    if (ready[S1+2]) begin
      m_tdata[15:0]    <= sat_pack((VW+1)'(p_cpcy));
      m_tdata[31:16]   <= sat_pack((VW+1)'(p_cpsy));
      m_tdata[47:32]   <= sat_pack(-(VW+1)'(p_nsp));
      m_tdata[63:48]   <= sat_pack((VW+1)'(p_crsy) - (VW+1)'(p_srspcy));
      m_tdata[79:64]   <= sat_pack(-(VW+1)'(p_srspsy) - (VW+1)'(p_crcy));
      m_tdata[95:80]   <= sat_pack(-(VW+1)'(p_srcp));
      m_tdata[111:96]  <= sat_pack((VW+1)'(p_crspcy) + (VW+1)'(p_srsy));
      m_tdata[127:112] <= sat_pack((VW+1)'(p_crspsy) - (VW+1)'(p_srcy));
      m_tdata[143:128] <= sat_pack((VW+1)'(p_crcp));
    end
  end

endmodule
